[src/banked_console_memory_map_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the banked console memory map
// Shared macros for the concurrent checks of the memory map RTL.
// ----------------------------------------------------------------------------
`ifndef BANKED_CONSOLE_MEMORY_MAP_ASSERT_SVH
`define BANKED_CONSOLE_MEMORY_MAP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCMM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bcmm assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BCMM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bcmm assertion failed");

`endif

[src/bcmm_pkg.sv]
// ----------------------------------------------------------------------------
// Banked console memory map package
// Shared constants, access record type and palette index helper.
// ----------------------------------------------------------------------------
package bcmm_pkg;

  localparam int unsigned WRAM_BANK_BYTES = 4096;
  localparam int unsigned WRAM_BANKS_DEF  = 8;
  localparam int unsigned VRAM_DEPTH      = 16384;
  localparam int unsigned OAM_DEPTH       = 160;
  localparam int unsigned HRAM_DEPTH      = 127;
  localparam int unsigned PAL_DEPTH       = 64;

  localparam logic [15:0] ECHO_LO     = 16'hE000;
  localparam logic [15:0] ECHO_HI     = 16'hFDFF;
  localparam logic [15:0] ECHO_OFFSET = 16'h2000;
  localparam logic [7:0]  OAM_PAGE    = 8'hFE;
  localparam logic [7:0]  OAM_LAST    = 8'h9F;
  localparam logic [15:0] HRAM_LO     = 16'hFF80;
  localparam logic [15:0] HRAM_HI     = 16'hFFFE;

  localparam logic [15:0] ADDR_VRAM_BANK = 16'hFF4F;
  localparam logic [15:0] ADDR_BCPS      = 16'hFF68;
  localparam logic [15:0] ADDR_BCPD      = 16'hFF69;
  localparam logic [15:0] ADDR_OCPS      = 16'hFF6A;
  localparam logic [15:0] ADDR_OCPD      = 16'hFF6B;
  localparam logic [15:0] ADDR_WRAM_BANK = 16'hFF70;
  localparam logic [15:0] ADDR_IE        = 16'hFFFF;

  typedef logic [2:0] src_t;
  localparam src_t SRC_BYTE = 3'd0;
  localparam src_t SRC_VRAM = 3'd1;
  localparam src_t SRC_WRAM = 3'd2;
  localparam src_t SRC_OAM  = 3'd3;
  localparam src_t SRC_HRAM = 3'd4;
  localparam src_t SRC_BGP  = 3'd5;
  localparam src_t SRC_OBP  = 3'd6;

  typedef struct packed {
    src_t       src;
    logic [7:0] data;
    logic       handled;
    logic       wr;
  } acc_t;

  function automatic logic [7:0] pal_next_index(input logic [7:0] idx);
    logic [7:0] res;
    if (idx[7]) begin
      res = {2'b10, idx[5:0] + 6'd1};
    end else begin
      res = idx;
    end
    return res;
  endfunction

endpackage

[src/bcmm_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle; read data is registered and holds while idle.
// ----------------------------------------------------------------------------
module bcmm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en && we) begin
      mem[addr] <= wdata;
    end
    if (en && !we) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/banked_console_memory_map.sv]
// An accepted item is registered in stage 1, then in the output register; each
// touches at most one RAM port. One item per cycle unless out_stall holds.
// Reset clears the bank, palette index and interrupt-enable registers and
// the pipeline valids; RAM contents are left as they are.
// ----------------------------------------------------------------------------
// Banked console memory map
// Decodes one byte access per item against banked video and work RAM,
// sprite attribute RAM, high RAM, palette RAMs and control registers.
// ----------------------------------------------------------------------------
`include "banked_console_memory_map_assert.svh"

module banked_console_memory_map
  import bcmm_pkg::*;
#(
  parameter int unsigned WRAM_BANKS = WRAM_BANKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic        out_handled
);

  localparam int unsigned WOFS_W  = $clog2(WRAM_BANK_BYTES);
  localparam int unsigned WBW     = $clog2(WRAM_BANKS);
  localparam int unsigned WRAM_AW = WBW + WOFS_W;
  localparam int unsigned VRAM_AW = $clog2(VRAM_DEPTH);
  localparam int unsigned OAM_AW  = $clog2(OAM_DEPTH);
  localparam int unsigned HRAM_AW = $clog2(HRAM_DEPTH);
  localparam int unsigned PAL_AW  = $clog2(PAL_DEPTH);

  logic [7:0] vbk_r;
  logic [2:0] svbk_r;
  logic [7:0] bcps_r;
  logic [7:0] ocps_r;
  logic [7:0] ie_r;

  acc_t s1_r;
  acc_t s1_nxt;
  logic s1_v_r;
  logic out_valid_r;
  logic [7:0] out_read_data_r;
  logic out_handled_r;

  logic accept;
  logic adv;
  logic wr;
  logic [15:0] ma;
  logic [2:0] wbank;

  logic vram_sel, wram_sel, oam_sel, hram_sel, bgp_sel, obp_sel;
  logic [WRAM_AW-1:0] wram_addr;
  logic [7:0] vram_q, wram_q, oam_q, hram_q, bgp_q, obp_q;
  logic [7:0] rd_mux;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = s1_v_r && !adv;
  assign accept   = in_valid && !in_stall;
  assign wr       = in_mode;

  always_comb begin
    wbank = (svbk_r == 3'd0) ? 3'd1 : svbk_r;
    for (int i = 0; i < 3; i++) begin
      if ({1'b0, wbank} >= 4'(WRAM_BANKS)) begin
        wbank = wbank - 3'(WRAM_BANKS);
      end
    end
  end

  always_comb begin
    if (in_address >= ECHO_LO && in_address <= ECHO_HI) begin
      ma = in_address - ECHO_OFFSET;
    end else begin
      ma = in_address;
    end
  end

  always_comb begin
    vram_sel = 1'b0;
    wram_sel = 1'b0;
    oam_sel  = 1'b0;
    hram_sel = 1'b0;
    bgp_sel  = 1'b0;
    obp_sel  = 1'b0;
    wram_addr = {WBW'(0), ma[WOFS_W-1:0]};
    s1_nxt.src     = SRC_BYTE;
    s1_nxt.data    = 8'd0;
    s1_nxt.handled = 1'b1;
    s1_nxt.wr      = wr;
    if (ma[15:13] == 3'b100) begin
      vram_sel   = 1'b1;
      s1_nxt.src = SRC_VRAM;
    end else if (ma[15:12] == 4'hC) begin
      wram_sel   = 1'b1;
      s1_nxt.src = SRC_WRAM;
    end else if (ma[15:12] == 4'hD) begin
      wram_sel   = 1'b1;
      wram_addr  = {wbank[WBW-1:0], ma[WOFS_W-1:0]};
      s1_nxt.src = SRC_WRAM;
    end else if (in_address[15:8] == OAM_PAGE) begin
      if (in_address[7:0] <= OAM_LAST) begin
        oam_sel    = 1'b1;
        s1_nxt.src = SRC_OAM;
      end
    end else if (in_address >= HRAM_LO && in_address <= HRAM_HI) begin
      hram_sel   = 1'b1;
      s1_nxt.src = SRC_HRAM;
    end else begin
      case (in_address)
        ADDR_VRAM_BANK: s1_nxt.data = vbk_r;
        ADDR_BCPS:      s1_nxt.data = bcps_r;
        ADDR_BCPD: begin
          bgp_sel    = 1'b1;
          s1_nxt.src = SRC_BGP;
        end
        ADDR_OCPS:      s1_nxt.data = ocps_r;
        ADDR_OCPD: begin
          obp_sel    = 1'b1;
          s1_nxt.src = SRC_OBP;
        end
        ADDR_WRAM_BANK: s1_nxt.data = {5'd0, svbk_r};
        ADDR_IE:        s1_nxt.data = ie_r;
        default:        s1_nxt.handled = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vbk_r  <= 8'd0;
      svbk_r <= 3'd0;
      bcps_r <= 8'd0;
      ocps_r <= 8'd0;
      ie_r   <= 8'd0;
    end else if (accept && wr) begin
      case (in_address)
        ADDR_VRAM_BANK: vbk_r  <= in_write_data;
        ADDR_BCPS:      bcps_r <= in_write_data;
        ADDR_BCPD:      bcps_r <= pal_next_index(bcps_r);
        ADDR_OCPS:      ocps_r <= in_write_data;
        ADDR_OCPD:      ocps_r <= pal_next_index(ocps_r);
        ADDR_WRAM_BANK: svbk_r <= in_write_data[2:0];
        ADDR_IE:        ie_r   <= in_write_data;
        default: ;
      endcase
    end
  end

  bcmm_ram #(.WIDTH(8), .DEPTH(VRAM_DEPTH)) u_vram (
    .clk(clk), .en(accept && vram_sel), .we(wr),
    .addr({vbk_r[0], ma[VRAM_AW-2:0]}), .wdata(in_write_data), .rdata(vram_q)
  );

  bcmm_ram #(.WIDTH(8), .DEPTH(WRAM_BANKS * WRAM_BANK_BYTES)) u_wram (
    .clk(clk), .en(accept && wram_sel), .we(wr),
    .addr(wram_addr), .wdata(in_write_data), .rdata(wram_q)
  );

  bcmm_ram #(.WIDTH(8), .DEPTH(OAM_DEPTH)) u_oam (
    .clk(clk), .en(accept && oam_sel), .we(wr),
    .addr(in_address[OAM_AW-1:0]), .wdata(in_write_data), .rdata(oam_q)
  );

  bcmm_ram #(.WIDTH(8), .DEPTH(HRAM_DEPTH)) u_hram (
    .clk(clk), .en(accept && hram_sel), .we(wr),
    .addr(in_address[HRAM_AW-1:0]), .wdata(in_write_data), .rdata(hram_q)
  );

  bcmm_ram #(.WIDTH(8), .DEPTH(PAL_DEPTH)) u_bgp (
    .clk(clk), .en(accept && bgp_sel), .we(wr),
    .addr(bcps_r[PAL_AW-1:0]), .wdata(in_write_data), .rdata(bgp_q)
  );

  bcmm_ram #(.WIDTH(8), .DEPTH(PAL_DEPTH)) u_obp (
    .clk(clk), .en(accept && obp_sel), .we(wr),
    .addr(ocps_r[PAL_AW-1:0]), .wdata(in_write_data), .rdata(obp_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
  end

  always_comb begin
    case (s1_r.src)
      SRC_VRAM: rd_mux = vram_q;
      SRC_WRAM: rd_mux = wram_q;
      SRC_OAM:  rd_mux = oam_q;
      SRC_HRAM: rd_mux = hram_q;
      SRC_BGP:  rd_mux = bgp_q;
      SRC_OBP:  rd_mux = obp_q;
      default:  rd_mux = s1_r.data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_v_r) begin
      out_read_data_r <= (s1_r.wr || !s1_r.handled) ? 8'd0 : rd_mux;
      out_handled_r   <= s1_r.handled;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;
  assign out_handled   = out_handled_r;

  `BCMM_ASSERT_SAME(a_stall_needs_stage, in_stall, s1_v_r && out_valid_r)
  `BCMM_ASSERT_SAME(a_unhandled_reads_zero, out_valid && !out_handled, out_read_data == 8'd0)
  `BCMM_ASSERT_NEXT(a_write_reads_zero, adv && s1_v_r && s1_r.wr, out_read_data == 8'd0)
  `BCMM_ASSERT_NEXT(a_bg_index_autoinc, accept && wr && in_address == ADDR_BCPD && bcps_r[7],
                    bcps_r[7] && !bcps_r[6])

endmodule

[sim/banked_console_memory_map_checker.sv]
// ----------------------------------------------------------------------------
// Banked console memory map checker
// Watches both channels of the memory map, predicts the result of every
// accepted item from its own copy of the RAMs and registers, and compares
// each returned item field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module banked_console_memory_map_checker
  import bcmm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_mode,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_read_data,
  input  logic        out_handled,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [7:0] read_data;
    logic       handled;
  } access_result_t;

  access_result_t awaited_q [$];
  int             mismatches;

  logic [7:0] vram_bytes    [VRAM_DEPTH];
  logic [7:0] wram_bytes    [WRAM_BANKS_DEF * WRAM_BANK_BYTES];
  logic [7:0] oam_bytes     [OAM_DEPTH];
  logic [7:0] hram_bytes    [HRAM_DEPTH];
  logic [7:0] bg_pal_bytes  [PAL_DEPTH];
  logic [7:0] obj_pal_bytes [PAL_DEPTH];
  logic [7:0] vbank_reg;
  logic [2:0] wbank_reg;
  logic [7:0] bg_index;
  logic [7:0] obj_index;
  logic [7:0] ie_reg;

  function automatic logic [7:0] advance_index(input logic [7:0] idx);
    logic [5:0] low;
    low = idx[5:0] + 6'd1;
    return idx[7] ? {2'b10, low} : idx;
  endfunction

  function automatic access_result_t settle_access(input logic wr, input logic [15:0] a,
                                                   input logic [7:0] d);
    access_result_t res;
    logic [15:0]    ea;
    logic [7:0]     rd;
    int unsigned    bank;
    int unsigned    slot;
    rd = 8'h00;
    res.handled = 1'b1;
    ea = (a >= ECHO_LO && a <= ECHO_HI) ? a - ECHO_OFFSET : a;
    if (ea[15:13] == 3'b100) begin
      slot = 32'({vbank_reg[0], ea[12:0]});
      if (wr) vram_bytes[slot] = d; else rd = vram_bytes[slot];
    end else if (ea[15:13] == 3'b110) begin
      bank = 32'(wbank_reg);
      if (bank == 0) bank = 1;
      bank = bank % WRAM_BANKS_DEF;
      if (!ea[12]) bank = 0;
      slot = bank * WRAM_BANK_BYTES + 32'(ea[11:0]);
      if (wr) wram_bytes[slot] = d; else rd = wram_bytes[slot];
    end else if (ea[15:8] == OAM_PAGE) begin
      // The unused tail of the sprite page reads zero and drops writes.
      if (ea[7:0] <= OAM_LAST) begin
        if (wr) oam_bytes[ea[7:0]] = d; else rd = oam_bytes[ea[7:0]];
      end
    end else if (ea >= HRAM_LO && ea <= HRAM_HI) begin
      slot = 32'(ea - HRAM_LO);
      if (wr) hram_bytes[slot] = d; else rd = hram_bytes[slot];
    end else begin
      case (ea)
        ADDR_VRAM_BANK: begin
          if (wr) vbank_reg = d; else rd = vbank_reg;
        end
        ADDR_BCPS: begin
          if (wr) bg_index = d; else rd = bg_index;
        end
        ADDR_BCPD: begin
          if (wr) begin
            bg_pal_bytes[bg_index[5:0]] = d;
            bg_index = advance_index(bg_index);
          end else begin
            rd = bg_pal_bytes[bg_index[5:0]];
          end
        end
        ADDR_OCPS: begin
          if (wr) obj_index = d; else rd = obj_index;
        end
        ADDR_OCPD: begin
          if (wr) begin
            obj_pal_bytes[obj_index[5:0]] = d;
            obj_index = advance_index(obj_index);
          end else begin
            rd = obj_pal_bytes[obj_index[5:0]];
          end
        end
        ADDR_WRAM_BANK: begin
          if (wr) wbank_reg = d[2:0]; else rd = {5'd0, wbank_reg};
        end
        ADDR_IE: begin
          if (wr) ie_reg = d; else rd = ie_reg;
        end
        default: begin
          res.handled = 1'b0;
        end
      endcase
    end
    res.read_data = (wr || !res.handled) ? 8'h00 : rd;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    access_result_t got;
    access_result_t want;
    if (!rst_n) begin
      vbank_reg = 8'h00;
      wbank_reg = 3'd0;
      bg_index = 8'h00;
      obj_index = 8'h00;
      ie_reg = 8'h00;
      awaited_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        awaited_q.push_back(settle_access(in_mode, in_address, in_write_data));
      end
      if (out_valid && !out_stall) begin
        got.read_data = out_read_data;
        got.handled = out_handled;
        if (awaited_q.size() == 0) begin
          $display("%0t: unexpected item: expected none, got read_data %02h handled %0b",
                   $time, got.read_data, got.handled);
          mismatches++;
        end else begin
          want = awaited_q.pop_front();
          if (got.read_data !== want.read_data) begin
            $display("%0t: read_data mismatch: expected %02h, got %02h",
                     $time, want.read_data, got.read_data);
            mismatches++;
          end
          if (got.handled !== want.handled) begin
            $display("%0t: handled mismatch: expected %0b, got %0b",
                     $time, want.handled, got.handled);
            mismatches++;
          end
        end
      end
    end
    fail_count <= mismatches;
    pending <= awaited_q.size();
  end

endmodule

[sim/banked_console_memory_map_tb.sv]
// ----------------------------------------------------------------------------
// Banked console memory map testbench
// Sends directed and then random byte accesses with random gaps while the
// result side stalls at random. Reads only reach RAM bytes that were written
// before; a checker beside the block predicts and compares every item.
// ----------------------------------------------------------------------------
module banked_console_memory_map_tb;
  import bcmm_pkg::*;

  typedef enum int unsigned {
    RGN_NONE,
    RGN_VRAM,
    RGN_WRAM,
    RGN_OAM,
    RGN_HRAM,
    RGN_BG_PAL,
    RGN_OBJ_PAL
  } storage_t;

  localparam int unsigned RANDOM_ITEMS = 800;
  localparam int unsigned DRAIN_LIMIT  = 5000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_mode;
  logic [15:0] in_address;
  logic [7:0]  in_write_data;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_read_data;
  logic        out_handled;
  int          fail_count;
  int          pending;

  logic        shadow_vbank;
  logic [2:0]  shadow_wbank;
  logic [7:0]  shadow_bg_idx;
  logic [7:0]  shadow_obj_idx;
  bit          seen_cells [int unsigned];
  logic [15:0] recent_q [$];
  int unsigned items_sent;
  int unsigned quiet_items;
  int unsigned stall_hold;
  int unsigned stall_pick;

  banked_console_memory_map uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_data (out_read_data),
    .out_handled   (out_handled)
  );

  banked_console_memory_map_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_data (out_read_data),
    .out_handled   (out_handled),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

  // Finds the RAM byte an access reaches, from the bank and index state
  // as it stands after every item sent so far.
  function automatic storage_t locate(input logic [15:0] a, output int unsigned slot);
    logic [15:0] ea;
    int unsigned bank;
    slot = 0;
    ea = (a >= ECHO_LO && a <= ECHO_HI) ? a - ECHO_OFFSET : a;
    if (ea[15:13] == 3'b100) begin
      slot = 32'({shadow_vbank, ea[12:0]});
      return RGN_VRAM;
    end
    if (ea[15:13] == 3'b110) begin
      bank = 32'(shadow_wbank);
      if (bank == 0) bank = 1;
      bank = bank % WRAM_BANKS_DEF;
      if (!ea[12]) bank = 0;
      slot = bank * WRAM_BANK_BYTES + 32'(ea[11:0]);
      return RGN_WRAM;
    end
    if (ea[15:8] == OAM_PAGE && ea[7:0] <= OAM_LAST) begin
      slot = 32'(ea[7:0]);
      return RGN_OAM;
    end
    if (ea >= HRAM_LO && ea <= HRAM_HI) begin
      slot = 32'(ea - HRAM_LO);
      return RGN_HRAM;
    end
    if (a == ADDR_BCPD) begin
      slot = 32'(shadow_bg_idx[5:0]);
      return RGN_BG_PAL;
    end
    if (a == ADDR_OCPD) begin
      slot = 32'(shadow_obj_idx[5:0]);
      return RGN_OBJ_PAL;
    end
    return RGN_NONE;
  endfunction

  function automatic int unsigned cell_key(input storage_t rgn, input int unsigned slot);
    return rgn * 65536 + slot;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet_items != 0) begin
      quiet_items--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      quiet_items = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic logic [15:0] pick_ram_address();
    logic [15:0] a;
    logic [7:0]  low;
    case ($urandom_range(0, 4))
      0: a = 16'($urandom_range(16'h9FFF, 16'h8000));
      1: a = 16'($urandom_range(16'hDFFF, 16'hC000));
      2: a = 16'($urandom_range(ECHO_HI, ECHO_LO));
      3: begin
        low = 8'($urandom_range(OAM_LAST, 0));
        a = {OAM_PAGE, low};
      end
      default: a = 16'($urandom_range(HRAM_HI, HRAM_LO));
    endcase
    return a;
  endfunction

  function automatic logic [15:0] pick_ctrl_port();
    logic [15:0] a;
    case ($urandom_range(0, 6))
      0: a = ADDR_VRAM_BANK;
      1: a = ADDR_BCPS;
      2: a = ADDR_BCPD;
      3: a = ADDR_OCPS;
      4: a = ADDR_OCPD;
      5: a = ADDR_WRAM_BANK;
      default: a = ADDR_IE;
    endcase
    return a;
  endfunction

  function automatic void remember(input logic [15:0] a);
    recent_q.push_back(a);
    if (recent_q.size() > 48) void'(recent_q.pop_front());
  endfunction

  // A read of a byte never written is turned into a write of that byte.
  task automatic send_item(input logic wr, input logic [15:0] a, input logic [7:0] d);
    storage_t    rgn;
    int unsigned slot;
    int unsigned gap;
    rgn = locate(a, slot);
    if (!wr && rgn != RGN_NONE && !seen_cells.exists(cell_key(rgn, slot))) wr = 1'b1;
    if (wr && rgn != RGN_NONE) seen_cells[cell_key(rgn, slot)] = 1'b1;
    if (wr) begin
      case (a)
        ADDR_VRAM_BANK: shadow_vbank = d[0];
        ADDR_WRAM_BANK: shadow_wbank = d[2:0];
        ADDR_BCPS: shadow_bg_idx = d;
        ADDR_OCPS: shadow_obj_idx = d;
        ADDR_BCPD: begin
          if (shadow_bg_idx[7]) shadow_bg_idx = {2'b10, shadow_bg_idx[5:0] + 6'd1};
        end
        ADDR_OCPD: begin
          if (shadow_obj_idx[7]) shadow_obj_idx = {2'b10, shadow_obj_idx[5:0] + 6'd1};
        end
        default: ;
      endcase
    end
    in_valid <= 1'b1;
    in_mode <= wr;
    in_address <= a;
    in_write_data <= d;
    do @(posedge clk); while (in_stall);
    items_sent++;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic random_access();
    int unsigned pick;
    int unsigned n;
    logic [15:0] a;
    logic [15:0] port;
    logic [15:0] r16;
    logic [7:0]  base;
    pick = $urandom_range(0, 99);
    r16 = 16'($urandom_range(16'hFFFF, 0));
    if (pick < 30) begin
      a = pick_ram_address();
      send_item(1'b1, a, 8'($urandom_range(255, 0)));
      remember(a);
    end else if (pick < 55) begin
      if (recent_q.size() != 0) a = recent_q[$urandom_range(recent_q.size() - 1, 0)];
      else a = pick_ram_address();
      send_item(1'b0, a, 8'($urandom_range(255, 0)));
    end else if (pick < 63) begin
      send_item(1'b1, pick_ctrl_port(), 8'($urandom_range(255, 0)));
    end else if (pick < 70) begin
      send_item(1'b0, pick_ctrl_port(), 8'($urandom_range(255, 0)));
    end else if (pick < 80) begin
      port = $urandom_range(0, 1) ? ADDR_BCPS : ADDR_OCPS;
      base = 8'($urandom_range(255, 0));
      base[7] = ($urandom_range(0, 3) != 0);
      n = $urandom_range(1, 6);
      send_item(1'b1, port, base);
      repeat (n) send_item(1'b1, port + 16'd1, 8'($urandom_range(255, 0)));
      send_item(1'b0, port, 8'h00);
      send_item(1'b1, port, base);
      send_item(1'b0, port + 16'd1, 8'h00);
    end else if (pick < 88) begin
      if ($urandom_range(0, 1)) begin
        send_item(1'b1, ADDR_VRAM_BANK, 8'($urandom_range(255, 0)));
        a = {3'b100, r16[12:0]};
      end else begin
        send_item(1'b1, ADDR_WRAM_BANK, 8'($urandom_range(255, 0)));
        a = r16[15] ? {4'hD, r16[11:0]} : 16'hF000 + r16[8:0];
      end
      send_item(1'b1, a, 8'($urandom_range(255, 0)));
      remember(a);
      send_item(1'b0, a, 8'($urandom_range(255, 0)));
    end else if (pick < 93) begin
      a = {OAM_PAGE, 8'hA0 + r16[6:0] % 8'h60};
      send_item(r16[15], a, 8'($urandom_range(255, 0)));
    end else begin
      send_item(1'($urandom_range(0, 1)), r16, 8'($urandom_range(255, 0)));
    end
  endtask

  initial begin
    out_stall <= 1'b0;
    stall_hold = 0;
    forever begin
      @(posedge clk);
      if (stall_hold != 0) begin
        stall_hold--;
      end else begin
        stall_pick = $urandom_range(0, 99);
        if (stall_pick < 55) begin
          out_stall <= 1'b0;
          stall_hold = $urandom_range(0, 6);
        end else if (stall_pick < 88) begin
          out_stall <= 1'b1;
          stall_hold = $urandom_range(0, 2);
        end else if (stall_pick < 94) begin
          out_stall <= 1'b1;
          stall_hold = $urandom_range(5, 20);
        end else begin
          out_stall <= 1'b0;
          stall_hold = $urandom_range(30, 90);
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned drained;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_mode <= 1'b0;
    in_address <= 16'h0000;
    in_write_data <= 8'h00;
    shadow_vbank = 1'b0;
    shadow_wbank = 3'd0;
    shadow_bg_idx = 8'h00;
    shadow_obj_idx = 8'h00;
    items_sent = 0;
    quiet_items = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_item(1'b0, ADDR_IE, 8'h00);
    send_item(1'b1, 16'h8000, 8'h00);
    send_item(1'b1, ADDR_VRAM_BANK, 8'hFF);
    send_item(1'b1, 16'h9FFF, 8'hFF);
    send_item(1'b0, ADDR_VRAM_BANK, 8'h00);
    send_item(1'b0, 16'h9FFF, 8'h00);
    send_item(1'b1, 16'hC000, 8'hA5);
    send_item(1'b0, 16'hE000, 8'h00);
    send_item(1'b1, 16'hD000, 8'h5A);
    send_item(1'b1, ADDR_WRAM_BANK, 8'h01);
    send_item(1'b0, 16'hD000, 8'h00);
    send_item(1'b1, ADDR_WRAM_BANK, 8'hFF);
    send_item(1'b0, ADDR_WRAM_BANK, 8'h00);
    send_item(1'b1, 16'hFDFF, 8'h96);
    send_item(1'b0, 16'hDDFF, 8'h00);
    send_item(1'b1, ADDR_BCPS, 8'hBF);
    send_item(1'b1, ADDR_BCPD, 8'h3C);
    send_item(1'b0, ADDR_BCPS, 8'h00);
    send_item(1'b1, ADDR_OCPS, 8'h3F);
    send_item(1'b1, ADDR_OCPD, 8'hC3);
    send_item(1'b0, ADDR_OCPD, 8'h00);
    send_item(1'b1, 16'hFE9F, 8'h77);
    send_item(1'b0, 16'hFE9F, 8'h00);
    send_item(1'b0, 16'hFEFF, 8'h00);
    send_item(1'b1, HRAM_HI, 8'h81);
    send_item(1'b0, HRAM_HI, 8'h00);
    send_item(1'b0, 16'h0000, 8'h00);

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) random_access();
    in_valid <= 1'b0;

    drained = 0;
    do begin
      @(posedge clk);
      drained++;
    end while (pending != 0 && drained < DRAIN_LIMIT);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/bcmm_pkg.sv
src/bcmm_ram.sv
src/banked_console_memory_map.sv
sim/banked_console_memory_map_checker.sv
sim/banked_console_memory_map_tb.sv
